### rtl/ip_blocklist_port_allowlist_filter_assert.svh
// Assertion macros for the IP blocklist / port allowlist filter.
`ifndef IP_BLOCKLIST_PORT_ALLOWLIST_FILTER_ASSERT_SVH
`define IP_BLOCKLIST_PORT_ALLOWLIST_FILTER_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define IPBPAF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ipbpaf assertion failed");

// Next-cycle implication, disabled in reset.
`define IPBPAF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ipbpaf assertion failed");

`endif

### rtl/ipbpaf_pkg.sv
// Types, constants and hash function shared by the filter modules.
package ipbpaf_pkg;

  // Blocklist hash set geometry (BLOCK_SETS must be a power of two)
  localparam int BLOCK_SETS = 4096;
  localparam int BLOCK_WAYS = 4;
  localparam int SET_W      = $clog2(BLOCK_SETS);
  localparam int WAY_IDX_W  = (BLOCK_WAYS > 1) ? $clog2(BLOCK_WAYS) : 1;

  // Port bitmaps: 65536 bits each, stored as rows of PORT_WORD bits
  localparam int PORT_BITS  = 16;
  localparam int PORT_WORD  = 16;
  localparam int PORT_LSB_W = $clog2(PORT_WORD);
  localparam int PORT_ROWS  = (1 << PORT_BITS) / PORT_WORD;
  localparam int PORT_ROW_W = $clog2(PORT_ROWS);

  // Clearing sweep covers the deeper of the two memories
  localparam int CLR_DEPTH  = (BLOCK_SETS > PORT_ROWS) ? BLOCK_SETS : PORT_ROWS;
  localparam int CLR_W      = $clog2(CLR_DEPTH);

  localparam int CFG_ADDR_W = 3;

  localparam logic [31:0] HASH_MULT  = 32'h9E3779B1;
  localparam int          HASH_SHIFT = 8;

  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;

  localparam logic [15:0] MIN_IP_LEN  = 16'd34;
  localparam logic [15:0] MIN_UDP_LEN = 16'd42;
  localparam logic [15:0] MIN_TCP_LEN = 16'd54;

  localparam logic [1:0] VERDICT_PASS = 2'd0;
  localparam logic [1:0] VERDICT_DROP = 2'd1;
  localparam logic [1:0] VERDICT_ECHO = 2'd2;

  localparam logic [1:0] STS_OK       = 2'd0;
  localparam logic [1:0] STS_FULL     = 2'd1;
  localparam logic [1:0] STS_NOTFOUND = 2'd2;

  localparam logic [2:0] CMD_CLASSIFY     = 3'd0;
  localparam logic [2:0] CMD_BLOCK_INSERT = 3'd1;
  localparam logic [2:0] CMD_BLOCK_DELETE = 3'd2;
  localparam logic [2:0] CMD_UDP_ALLOW    = 3'd3;
  localparam logic [2:0] CMD_UDP_DISALLOW = 3'd4;
  localparam logic [2:0] CMD_TCP_ALLOW    = 3'd5;
  localparam logic [2:0] CMD_TCP_DISALLOW = 3'd6;

  localparam logic CFG_UDP_STRICT = 1'b0;
  localparam logic CFG_TCP_STRICT = 1'b1;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] frame_len;
    logic [15:0] eth_type;
    logic [47:0] dst_mac;
    logic [47:0] src_mac;
    logic [7:0]  ip_proto;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] l4_dst_port;
    logic [31:0] table_key;
    logic        entry_echo;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  verdict;
    logic [47:0] out_dst_mac;
    logic [47:0] out_src_mac;
    logic [31:0] out_src_ip;
    logic [31:0] out_dst_ip;
    logic [1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic        valid;
    logic        echo;
    logic [31:0] key;
  } way_t;

  typedef way_t [BLOCK_WAYS-1:0] set_row_t;

  typedef struct packed {
    logic [PORT_WORD-1:0] tcp;
    logic [PORT_WORD-1:0] udp;
  } port_row_t;

  typedef struct packed {
    logic                 hit;
    logic [WAY_IDX_W-1:0] hit_way;
    logic                 hit_echo;
    logic                 free;
    logic [WAY_IDX_W-1:0] free_way;
  } lookup_t;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_t;

  function automatic logic [SET_W-1:0] set_of(logic [31:0] key);
    logic [31:0] h;
    h = key * HASH_MULT;
    return h[HASH_SHIFT +: SET_W];
  endfunction

endpackage

### rtl/ip_blocklist_port_allowlist_filter.sv
// Top level of the IPv4 source blocklist and L4 destination port allowlist filter.
// Each transaction either classifies one frame header (pass, drop, or echo with
// MACs and IPs swapped) or applies one table command to the blocklist hash set or
// to the UDP/TCP port allow bitmaps; every transaction yields exactly one result.
// In a transaction, the accept cycle addresses the set memory (one
// row holds all BLOCK_WAYS ways of a set) and the port bitmap memory, and the
// following cycle matches, builds the result and writes the modified row back.
// No new transaction is accepted while one executes. Results sit in an output
// register backed by a one-entry skid, so one more transaction can be taken while
// a result waits; in_ready stays low while the skid holds a result.
// After reset a clearing sweep writes zero to both memories, one row per cycle,
// over CLR_DEPTH row addresses (4096 with the default geometry); in_ready stays low until
// it is done. The APB registers (udp_strict at 0x0, tcp_strict at 0x4) are
// accepted at any time, but should only be written while the filter is idle.
`include "ip_blocklist_port_allowlist_filter_assert.svh"

module ip_blocklist_port_allowlist_filter (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input transactions
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  ipbpaf_pkg::in_item_t                 in_data,
  // result transactions
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output ipbpaf_pkg::out_item_t                out_data,
  // APB configuration
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [ipbpaf_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);
  import ipbpaf_pkg::*;

  state_t state_r, state_nxt;
  logic [CLR_W-1:0] clr_cnt_r;

  // transaction held for the execute cycle
  in_item_t                 item_r;
  logic [SET_W-1:0]         set_addr_r;
  logic [PORT_ROW_W-1:0]    port_addr_r;
  logic [PORT_LSB_W-1:0]    port_bit_r;

  logic udp_strict_r, tcp_strict_r;

  // result register plus skid
  logic      out_valid_r, skid_valid_r;
  out_item_t out_data_r, skid_data_r;

  logic                  in_acc;
  logic                  out_free;
  logic                  exec_stall;
  logic [31:0]           rd_key;
  logic [15:0]           rd_port;
  logic [SET_W-1:0]      set_raddr;

  set_row_t  set_rrow, set_wrow, set_mem_wdata;
  port_row_t port_rrow, port_wrow, port_mem_wdata;
  logic                  set_we, port_we;
  logic                  set_mem_we, port_mem_we;
  logic [SET_W-1:0]      set_mem_waddr;
  logic [PORT_ROW_W-1:0] port_mem_waddr;
  logic                  clr_set_rows, clr_port_rows;

  lookup_t   lk;
  out_item_t res;

  // ---------------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------------
  assign in_ready  = (state_r == ST_IDLE) && !skid_valid_r;
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;

  // execute cycle while the output register is still held
  assign exec_stall = (state_r == ST_EXEC) && out_valid_r && !out_ready;

  // ---------------------------------------------------------------------------
  // Read addressing at accept: classify looks up the source IP and the L4
  // destination port; table commands use table_key for both.
  // ---------------------------------------------------------------------------
  assign rd_key    = (in_data.cmd == CMD_CLASSIFY) ? in_data.src_ip : in_data.table_key;
  assign rd_port   = (in_data.cmd == CMD_CLASSIFY) ? in_data.l4_dst_port
                                                   : in_data.table_key[15:0];
  assign set_raddr = set_of(rd_key);

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r      <= in_data;
      set_addr_r  <= set_raddr;
      port_addr_r <= rd_port[PORT_BITS-1:PORT_LSB_W];
      port_bit_r  <= rd_port[PORT_LSB_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: clear sweep, then idle / execute
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == CLR_W'(CLR_DEPTH - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) state_nxt = ST_EXEC;
      end
      ST_EXEC: state_nxt = ST_IDLE;
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Memories
  // ---------------------------------------------------------------------------
  ipbpaf_ram #(
    .WIDTH ($bits(set_row_t)),
    .DEPTH (BLOCK_SETS)
  ) u_set_ram (
    .clk   (clk),
    .we    (set_mem_we),
    .waddr (set_mem_waddr),
    .wdata (set_mem_wdata),
    .re    (in_acc),
    .raddr (set_raddr),
    .rdata (set_rrow)
  );

  ipbpaf_ram #(
    .WIDTH ($bits(port_row_t)),
    .DEPTH (PORT_ROWS)
  ) u_port_ram (
    .clk   (clk),
    .we    (port_mem_we),
    .waddr (port_mem_waddr),
    .wdata (port_mem_wdata),
    .re    (in_acc),
    .raddr (rd_port[PORT_BITS-1:PORT_LSB_W]),
    .rdata (port_rrow)
  );

  // the sweep runs to the deeper memory; the shallower one stops at its depth
  assign clr_set_rows  = {1'b0, clr_cnt_r} < (CLR_W + 1)'(BLOCK_SETS);
  assign clr_port_rows = {1'b0, clr_cnt_r} < (CLR_W + 1)'(PORT_ROWS);

  always_comb begin
    if (state_r == ST_CLEAR) begin
      set_mem_we     = clr_set_rows;
      set_mem_waddr  = clr_cnt_r[SET_W-1:0];
      set_mem_wdata  = '0;
      port_mem_we    = clr_port_rows;
      port_mem_waddr = clr_cnt_r[PORT_ROW_W-1:0];
      port_mem_wdata = '0;
    end else begin
      set_mem_we     = (state_r == ST_EXEC) && set_we;
      set_mem_waddr  = set_addr_r;
      set_mem_wdata  = set_wrow;
      port_mem_we    = (state_r == ST_EXEC) && port_we;
      port_mem_waddr = port_addr_r;
      port_mem_wdata = port_wrow;
    end
  end

  // ---------------------------------------------------------------------------
  // Execute: match, classify or modify, write back
  // ---------------------------------------------------------------------------
  ipbpaf_set_match u_match (
    .row (set_rrow),
    .key ((item_r.cmd == CMD_CLASSIFY) ? item_r.src_ip : item_r.table_key),
    .res (lk)
  );

  always_comb begin
    res       = '0;
    set_we    = 1'b0;
    set_wrow  = set_rrow;
    port_we   = 1'b0;
    port_wrow = port_rrow;
    case (item_r.cmd)
      CMD_CLASSIFY: begin
        res.out_dst_mac = item_r.dst_mac;
        res.out_src_mac = item_r.src_mac;
        res.out_src_ip  = item_r.src_ip;
        res.out_dst_ip  = item_r.dst_ip;
        res.verdict     = VERDICT_PASS;
        // short or non-IPv4 frames pass untouched
        if (item_r.frame_len >= MIN_IP_LEN && item_r.eth_type == ETYPE_IPV4) begin
          if (lk.hit) begin
            if (lk.hit_echo) begin
              res.out_dst_mac = item_r.src_mac;
              res.out_src_mac = item_r.dst_mac;
              res.out_src_ip  = item_r.dst_ip;
              res.out_dst_ip  = item_r.src_ip;
              res.verdict     = VERDICT_ECHO;
            end else begin
              res.verdict = VERDICT_DROP;
            end
          end else if (item_r.ip_proto == PROTO_UDP && udp_strict_r) begin
            if (item_r.frame_len >= MIN_UDP_LEN && !port_rrow.udp[port_bit_r])
              res.verdict = VERDICT_DROP;
          end else if (item_r.ip_proto == PROTO_TCP && tcp_strict_r) begin
            if (item_r.frame_len >= MIN_TCP_LEN && !port_rrow.tcp[port_bit_r])
              res.verdict = VERDICT_DROP;
          end
        end
      end
      CMD_BLOCK_INSERT: begin
        if (lk.hit) begin
          // present key: only the action bit changes
          set_wrow[lk.hit_way].echo = item_r.entry_echo;
          set_we = 1'b1;
        end else if (lk.free) begin
          set_wrow[lk.free_way].valid = 1'b1;
          set_wrow[lk.free_way].echo  = item_r.entry_echo;
          set_wrow[lk.free_way].key   = item_r.table_key;
          set_we = 1'b1;
        end else begin
          res.status = STS_FULL;
        end
      end
      CMD_BLOCK_DELETE: begin
        if (lk.hit) begin
          set_wrow[lk.hit_way].valid = 1'b0;
          set_wrow[lk.hit_way].echo  = 1'b0;
          set_we = 1'b1;
        end else begin
          res.status = STS_NOTFOUND;
        end
      end
      CMD_UDP_ALLOW: begin
        port_wrow.udp[port_bit_r] = 1'b1;
        port_we = 1'b1;
      end
      CMD_UDP_DISALLOW: begin
        port_wrow.udp[port_bit_r] = 1'b0;
        port_we = 1'b1;
      end
      CMD_TCP_ALLOW: begin
        port_wrow.tcp[port_bit_r] = 1'b1;
        port_we = 1'b1;
      end
      CMD_TCP_DISALLOW: begin
        port_wrow.tcp[port_bit_r] = 1'b0;
        port_we = 1'b1;
      end
      default: ;  // unused code: no change, all-zero result
    endcase
  end

  // ---------------------------------------------------------------------------
  // Result register and skid. The skid is empty whenever EXEC runs, since
  // accept requires it empty and only EXEC fills it.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (state_r == ST_EXEC) begin
      if (out_free) out_valid_r  <= 1'b1;
      else          skid_valid_r <= 1'b1;
    end else if (skid_valid_r && out_free) begin
      out_valid_r  <= 1'b1;
      skid_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_EXEC) begin
      if (out_free) out_data_r  <= res;
      else          skid_data_r <= res;
    end else if (skid_valid_r && out_free) begin
      out_data_r <= skid_data_r;
    end
  end

  // ---------------------------------------------------------------------------
  // APB registers
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      udp_strict_r <= 1'b0;
      tcp_strict_r <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        CFG_UDP_STRICT: udp_strict_r <= pwdata[0];
        CFG_TCP_STRICT: tcp_strict_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      CFG_UDP_STRICT: prdata = {31'd0, udp_strict_r};
      CFG_TCP_STRICT: prdata = {31'd0, tcp_strict_r};
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `IPBPAF_ASSERT_NEXT(a_acc_to_exec, clk, rst_n, in_acc, state_r == ST_EXEC)
  `IPBPAF_ASSERT_NOW(a_no_acc_in_clear, clk, rst_n, state_r == ST_CLEAR, !in_ready)
  `IPBPAF_ASSERT_NOW(a_skid_behind_out, clk, rst_n, skid_valid_r, out_valid_r)
  `IPBPAF_ASSERT_NEXT(a_exec_stall_to_skid, clk, rst_n, exec_stall, skid_valid_r && out_valid_r)
  `IPBPAF_ASSERT_NOW(a_no_write_at_read, clk, rst_n, in_acc, !set_mem_we && !port_mem_we)

endmodule

### rtl/ipbpaf_ram.sv
// Generic simple dual-port RAM with registered read.
module ipbpaf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/ipbpaf_set_match.sv
// Way compare and priority select for one blocklist set row.
module ipbpaf_set_match (
  input  ipbpaf_pkg::set_row_t row,
  input  logic [31:0]          key,
  output ipbpaf_pkg::lookup_t  res
);
  import ipbpaf_pkg::*;

  // walk high to low so the lowest matching / free way wins
  always_comb begin
    res = '0;
    for (int w = BLOCK_WAYS - 1; w >= 0; w--) begin
      if (row[w].valid && row[w].key == key) begin
        res.hit      = 1'b1;
        res.hit_way  = WAY_IDX_W'(w);
        res.hit_echo = row[w].echo;
      end
      if (!row[w].valid) begin
        res.free     = 1'b1;
        res.free_way = WAY_IDX_W'(w);
      end
    end
  end

endmodule
